FILE: rtl/bua_pkg.sv
`timescale 1ns / 1ps
package bua_pkg;

	typedef struct packed {
		logic signed [13:0] top;
		logic        [11:0] height;
		logic signed [12:0] left;
		logic        [11:0] width;
		logic signed [16:0] life;
		logic        [15:0] ident;
	} bua_entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic       scan_load;
		logic       scan_shift;
		logic       wr_en;
		logic       ins_en;
		logic [7:0] ptr;
		bua_entry_t data;
	} bua_ctrl_t;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_HIT   = 3'd2;
	localparam logic [2:0] OP_BLOCK = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] ST_PLACED = 2'd0;
	localparam logic [1:0] ST_DENSE  = 2'd1;
	localparam logic [1:0] ST_NOROOM = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [7:0] CFG_TOP    = 8'd0;
	localparam logic [7:0] CFG_BOTTOM = 8'd1;
	localparam logic [7:0] CFG_WIDTH  = 8'd2;
	localparam logic [7:0] CFG_MARGIN = 8'd3;
	localparam logic [7:0] CFG_DENSE  = 8'd4;
	localparam logic [7:0] CFG_LIFE   = 8'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_OUT
	} bua_state_t;

endpackage

FILE: rtl/bua_cell.sv
`timescale 1ns / 1ps
module bua_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  bua_pkg::bua_ctrl_t  ctrl,
	input  bua_pkg::bua_entry_t prev_entry,
	input  bua_pkg::bua_entry_t next_scan,
	output bua_pkg::bua_entry_t entry,
	output bua_pkg::bua_entry_t scan
);
	import bua_pkg::*;

	localparam logic [7:0] MY_IDX = 8'(IDX);

	bua_entry_t entry_q;
	bua_entry_t scan_q;

	// scan copy shifts towards cell 0, the sequencer reads it there
	always_ff @(posedge clk) begin
		if (ctrl.scan_load) begin
			scan_q <= entry_q;
		end else if (ctrl.scan_shift) begin
			scan_q <= next_scan;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && (MY_IDX > ctrl.ptr)) begin
			entry_q <= prev_entry;
		end else if ((ctrl.ins_en || ctrl.wr_en) && (MY_IDX == ctrl.ptr)) begin
			entry_q <= ctrl.data;
		end
	end

	assign entry = entry_q;
	assign scan  = scan_q;

endmodule

FILE: rtl/bottom_up_slot_allocator_core.sv
`timescale 1ns / 1ps
// Slot allocator for vertically stacked boxes, held in a row of MAX_BOXES cells ordered from
// the bottom up. Every item is one transaction in and one result transaction out. For a walk,
// the stored list is copied into a scan chain and the sequencer steps through it one box per cycle
// (add stops at the first fit or when the top is reached, hit test at the first hit); clear,
// unknown opcodes and an add to a full table skip the walk. Inserts shift the row up; tick and
// block compact it in place during the walk. The next item is taken while the previous result
// still waits on the master side.
module bottom_up_slot_allocator_core #(
	parameter int MAX_BOXES  = 32,
	parameter int COORD_BITS = 12,
	localparam int CW        = $clog2(MAX_BOXES + 1),
	localparam int OW        = ((46 + CW + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// item_id, item_width, item_height, tick_step, point_x, point_y
	input  logic [79:0]   s_tdata,
	// opcode
	input  logic [2:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// add_status, placed_x, placed_y, hit_found, hit_id, box_count, zero fill
	output logic [OW-1:0] m_tdata
);
	import bua_pkg::*;

	localparam int CB = (COORD_BITS < 12) ? COORD_BITS : 12;
	localparam logic [11:0] CMASK = 12'((13'd1 << CB) - 13'd1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BOXES);

	// configuration
	logic [11:0] top_q, bottom_q, swidth_q;
	logic [7:0]  margin_q;
	logic        dense_q;
	logic [15:0] life_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= 12'd0;
			bottom_q <= 12'd1080;
			swidth_q <= 12'd1920;
			margin_q <= 8'd2;
			dense_q  <= 1'b0;
			life_q   <= 16'd5000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TOP:    top_q    <= cfg_data[11:0] & CMASK;
				CFG_BOTTOM: bottom_q <= cfg_data[11:0] & CMASK;
				CFG_WIDTH:  swidth_q <= cfg_data[11:0] & CMASK;
				CFG_MARGIN: margin_q <= cfg_data[7:0];
				CFG_DENSE:  dense_q  <= cfg_data[0];
				CFG_LIFE:   life_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell row
	bua_ctrl_t  ctrl;
	bua_entry_t ent [MAX_BOXES];
	bua_entry_t scn [MAX_BOXES];

	for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
		bua_cell #(.IDX(k)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.prev_entry ((k == 0) ? ent[0] : ent[(k == 0) ? 0 : k - 1]),
			.next_scan  ((k == MAX_BOXES - 1) ? scn[k] : scn[(k == MAX_BOXES - 1) ? k : k + 1]),
			.entry      (ent[k]),
			.scan       (scn[k])
		);
	end

	bua_entry_t e;
	assign e = scn[0];

	// sequencer state
	bua_state_t state_q, state_d;
	logic [CW-1:0] total_q, i_q, w_q, msp_q;
	logic          msv_q;
	logic [2:0]    op_q;
	logic [15:0]   id_q, step_q;
	logic [11:0]   iw_q, ih_q, px_q, py_q;
	logic signed [17:0] cur_q, cy_q, maxs_q, ds_q;
	logic [1:0]    st_q;
	logic signed [12:0] ox_q;
	logic [13:0]   oy_q;
	logic          hit_q;
	logic [15:0]   hid_q;
	logic          mvalid_q;
	logic [OW-1:0] mdata_q;

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// walk arithmetic
	logic signed [17:0] t18, hh18, m18, h18, top18, tmp, ncy, ncur, nds, ec, dds;
	logic signed [17:0] nl;
	logic signed [12:0] dx, xpos;
	logic signed [14:0] lw, tp;
	logic signed [13:0] pxs, pys;
	logic fit, upd, brk, at_end, dmv, pt_hit;
	logic [CW-1:0] dmp;

	// walk outcome
	logic fin, kept, tot_inc, hit_now, placed;
	logic [1:0] n_st;
	logic [13:0] n_oy;

	assign t18   = 18'(e.top);
	assign hh18  = $signed({6'd0, e.height});
	assign m18   = $signed({10'd0, margin_q});
	assign h18   = $signed({6'd0, ih_q});
	assign top18 = $signed({6'd0, top_q});
	assign fit   = (cur_q - t18 - hh18 - m18) >= h18;
	assign tmp   = cy_q - t18;
	assign upd   = tmp > maxs_q;
	assign nds   = cy_q - (tmp >>> 1);
	assign ncy   = t18 - m18;
	assign ncur  = ncy - h18;
	assign brk   = ncur <= top18;
	assign at_end = (i_q == total_q);
	assign dx    = $signed({1'b0, swidth_q}) - $signed({1'b0, iw_q});
	assign xpos  = dx >>> 1;
	assign nl    = 18'(e.life) - $signed({2'd0, step_q});
	assign pxs   = $signed({2'd0, px_q});
	assign pys   = $signed({2'd0, py_q});
	assign lw    = 15'(e.left) + $signed({3'd0, e.width});
	assign tp    = 15'(e.top) + $signed({3'd0, e.height});
	assign pt_hit = (14'(e.left) < pxs) && (lw > 15'(pxs)) && (e.top < pys) && (tp > 15'(pys));

	// at the end of the list the registered walk values hold; on a break the last box counts
	assign ec  = at_end ? cur_q : ncur;
	assign dmv = at_end ? msv_q : (upd || msv_q);
	assign dmp = (at_end || !upd) ? msp_q : i_q;
	assign dds = (at_end || !upd) ? ds_q : nds;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_TICK || s_tuser == OP_HIT || s_tuser == OP_BLOCK ||
					    (s_tuser == OP_ADD && total_q != FULL_CNT)) begin
						state_d = S_WALK;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_WALK: begin
				if (fin) state_d = S_OUT;
			end
			S_OUT: begin
				if (!mvalid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl             = '0;
		ctrl.data        = e;
		ctrl.data.height = ih_q;
		ctrl.data.left   = xpos;
		ctrl.data.width  = iw_q;
		ctrl.data.life   = $signed({1'b0, life_q});
		ctrl.data.ident  = id_q;
		fin     = 1'b0;
		kept    = 1'b0;
		tot_inc = 1'b0;
		hit_now = 1'b0;
		placed  = 1'b0;
		n_st    = ST_PLACED;
		n_oy    = 14'd0;
		if (accept) ctrl.scan_load = 1'b1;
		if (state_q == S_WALK) begin
			ctrl.scan_shift = 1'b1;
			case (op_q)
				OP_ADD: begin
					if (!at_end && fit) begin
						fin = 1'b1;
						ctrl.ins_en   = 1'b1;
						ctrl.ptr      = 8'(i_q);
						ctrl.data.top = cur_q[13:0];
						n_oy    = cur_q[13:0];
						tot_inc = 1'b1;
						placed  = 1'b1;
					end else if (at_end || brk) begin
						fin = 1'b1;
						if (ec > top18) begin
							ctrl.ins_en   = 1'b1;
							ctrl.ptr      = 8'(total_q);
							ctrl.data.top = ec[13:0];
							n_oy    = ec[13:0];
							tot_inc = 1'b1;
							placed  = 1'b1;
						end else if (dense_q) begin
							ctrl.ins_en   = 1'b1;
							ctrl.ptr      = dmv ? 8'(dmp) : 8'(total_q);
							ctrl.data.top = dds[13:0];
							n_oy    = dds[13:0];
							n_st    = ST_DENSE;
							tot_inc = 1'b1;
							placed  = 1'b1;
						end else begin
							n_st = ST_NOROOM;
						end
					end
				end
				OP_TICK: begin
					if (at_end) begin
						fin = 1'b1;
					end else if (nl > 18'sd0) begin
						ctrl.wr_en     = 1'b1;
						ctrl.ptr       = 8'(w_q);
						ctrl.data      = e;
						ctrl.data.life = nl[16:0];
						kept = 1'b1;
					end
				end
				OP_BLOCK: begin
					if (at_end) begin
						fin = 1'b1;
					end else if (e.ident != id_q) begin
						ctrl.wr_en = 1'b1;
						ctrl.ptr   = 8'(w_q);
						ctrl.data  = e;
						kept = 1'b1;
					end
				end
				OP_HIT: begin
					if (at_end) begin
						fin = 1'b1;
					end else if (pt_hit) begin
						fin     = 1'b1;
						hit_now = 1'b1;
					end
				end
				default: fin = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			total_q  <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!mvalid_q || m_tready)) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			if (accept && s_tuser == OP_CLEAR) begin
				total_q <= '0;
			end else if (state_q == S_WALK && fin) begin
				if (op_q == OP_TICK || op_q == OP_BLOCK) total_q <= w_q;
				else if (tot_inc) total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			id_q   <= s_tdata[15:0];
			iw_q   <= s_tdata[27:16] & CMASK;
			ih_q   <= s_tdata[39:28] & CMASK;
			step_q <= s_tdata[55:40];
			px_q   <= s_tdata[67:56] & CMASK;
			py_q   <= s_tdata[79:68] & CMASK;
			i_q    <= '0;
			w_q    <= '0;
			msp_q  <= '0;
			msv_q  <= 1'b0;
			cur_q  <= $signed({6'd0, bottom_q}) - $signed({10'd0, margin_q});
			cy_q   <= $signed({6'd0, bottom_q}) - $signed({6'd0, top_q});
			maxs_q <= '0;
			ds_q   <= '0;
			st_q   <= (s_tuser == OP_ADD && total_q == FULL_CNT) ? ST_FULL : ST_PLACED;
			ox_q   <= '0;
			oy_q   <= '0;
			hit_q  <= 1'b0;
			hid_q  <= '0;
		end
		if (state_q == S_WALK) begin
			if (fin) begin
				if (op_q == OP_ADD) st_q <= n_st;
				if (placed) begin
					ox_q <= xpos;
					oy_q <= n_oy;
				end
				if (hit_now) begin
					hit_q <= 1'b1;
					hid_q <= e.ident;
				end
			end else begin
				i_q <= i_q + 1'b1;
				if (kept) w_q <= w_q + 1'b1;
				if (upd) begin
					maxs_q <= tmp;
					ds_q   <= nds;
					msp_q  <= i_q;
					msv_q  <= 1'b1;
				end
				cy_q  <= ncy;
				cur_q <= ncur;
			end
		end
		if (state_q == S_OUT && (!mvalid_q || m_tready)) begin
			mdata_q <= OW'({total_q, hid_q, hit_q, oy_q, ox_q, st_q});
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= FULL_CNT) else $error("box count beyond table size");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (w_q <= i_q)) else $error("compaction pointer ahead of walk");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("second transaction taken during an item");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import bua_pkg::*;

	localparam int NBOX      = 32;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] px;
		logic [13:0] py;
		logic        hit;
		logic [15:0] hid;
		logic [5:0]  cnt;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	bottom_up_slot_allocator_core u_top (.*);

	// shadow of the block's configuration and box list
	int sh_top, sh_bottom, sh_width, sh_margin, sh_dense, sh_life;
	int bx_top[NBOX], bx_h[NBOX], bx_left[NBOX], bx_w[NBOX], bx_life[NBOX];
	int bx_id[NBOX];
	int bx_total;

	alloc_result_t pending_q[$];
	int  mismatches;
	int  idle_cycles;
	bit  rx_hold;
	bit  rx_noidle;
	bit  tx_noidle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int wrap14(input int v);
		int u;
		u = v & 16'h3FFF;
		return (u >= 16'h2000) ? u - 16'h4000 : u;
	endfunction

	function automatic void shadow_reset();
		sh_top = 0; sh_bottom = 1080; sh_width = 1920;
		sh_margin = 2; sh_dense = 0; sh_life = 5000;
		bx_total = 0;
	endfunction

	function automatic void drop_box(input int i);
		for (int k = i; k < bx_total - 1; k++) begin
			bx_top[k] = bx_top[k+1]; bx_h[k] = bx_h[k+1]; bx_left[k] = bx_left[k+1];
			bx_w[k] = bx_w[k+1]; bx_life[k] = bx_life[k+1]; bx_id[k] = bx_id[k+1];
		end
		bx_total--;
	endfunction

	function automatic void insert_box(input int i, input int y, input int h, input int x,
			input int w, input int id);
		for (int k = bx_total; k > i; k--) begin
			bx_top[k] = bx_top[k-1]; bx_h[k] = bx_h[k-1]; bx_left[k] = bx_left[k-1];
			bx_w[k] = bx_w[k-1]; bx_life[k] = bx_life[k-1]; bx_id[k] = bx_id[k-1];
		end
		bx_top[i] = wrap14(y); bx_h[i] = h; bx_left[i] = x; bx_w[i] = w;
		bx_life[i] = sh_life; bx_id[i] = id;
		bx_total++;
	endfunction

	function automatic alloc_result_t place_or_query(input logic [2:0] op,
			input logic [79:0] d);
		alloc_result_t r;
		int id, w, h, step, px, py;
		int cur, cy, maxs, ds, dw, x, mspos, tmp, i, ox, oy;
		bit done;
		id = d[15:0]; w = d[27:16]; h = d[39:28]; step = d[55:40];
		px = d[67:56]; py = d[79:68];
		r = '{default: '0};
		ox = 0; oy = 0;
		case (op)
			OP_ADD: begin
				if (bx_total >= NBOX) begin
					r.status = ST_FULL;
				end else begin
					cur = sh_bottom - sh_margin;
					cy = sh_bottom - sh_top;
					maxs = 0; ds = 0; mspos = -1; done = 0;
					dw = sh_width - w;
					x = (dw >= 0) ? dw / 2 : -((1 - dw) / 2);
					for (i = 0; i < bx_total; i++) begin
						if (cur - bx_top[i] - bx_h[i] - sh_margin >= h) begin
							insert_box(i, cur, h, x, w, id);
							done = 1; oy = cur;
							break;
						end
						tmp = cy - bx_top[i];
						if (tmp > maxs) begin
							maxs = tmp; ds = cy - tmp / 2; mspos = i;
						end
						cy = bx_top[i] - sh_margin;
						cur = cy - h;
						if (cur <= sh_top) break;
					end
					if (!done) begin
						if (cur > sh_top) begin
							insert_box(bx_total, cur, h, x, w, id);
							oy = cur; done = 1;
						end else if (sh_dense != 0) begin
							insert_box(mspos < 0 ? bx_total : mspos, ds, h, x, w, id);
							oy = ds; r.status = ST_DENSE; done = 1;
						end else begin
							r.status = ST_NOROOM;
						end
					end
					if (done) begin
						ox = x; oy = wrap14(oy);
					end
				end
			end
			OP_TICK: begin
				i = 0;
				while (i < bx_total) begin
					bx_life[i] -= step;
					if (bx_life[i] > 0) i++;
					else drop_box(i);
				end
			end
			OP_HIT: begin
				for (i = 0; i < bx_total; i++) begin
					if (bx_left[i] < px && bx_left[i] + bx_w[i] > px &&
							bx_top[i] < py && bx_top[i] + bx_h[i] > py) begin
						r.hit = 1'b1; r.hid = bx_id[i];
						break;
					end
				end
			end
			OP_BLOCK: begin
				i = 0;
				while (i < bx_total) begin
					if (bx_id[i] == id) drop_box(i);
					else i++;
				end
			end
			OP_CLEAR: bx_total = 0;
			default: ;
		endcase
		r.px = ox[12:0];
		r.py = oy[13:0];
		r.cnt = bx_total[5:0];
		return r;
	endfunction

	// sender: called just after a rising edge, returns just after the accepting edge
	task automatic send_item(input logic [2:0] op, input logic [79:0] d);
		while (!tx_noidle && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		pending_q.push_back(place_or_query(op, d));
		@(posedge clk);
	endtask

	function automatic logic [79:0] pack_item(input int id, input int w, input int h,
			input int step, input int px, input int py);
		return {py[11:0], px[11:0], step[15:0], h[11:0], w[11:0], id[15:0]};
	endfunction

	task automatic add_box(input int id, input int w, input int h);
		send_item(OP_ADD, pack_item(id, w, h, 0, 0, 0));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (45) @(posedge clk);
	endtask

	// registers change only with the block empty
	task automatic write_reg(input logic [7:0] idx, input int val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[15:0];
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		case (idx)
			CFG_TOP:    sh_top    = val & 12'hFFF;
			CFG_BOTTOM: sh_bottom = val & 12'hFFF;
			CFG_WIDTH:  sh_width  = val & 12'hFFF;
			CFG_MARGIN: sh_margin = val & 8'hFF;
			CFG_DENSE:  sh_dense  = val & 1;
			CFG_LIFE:   sh_life   = val & 16'hFFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup_surface(input int top, input int bottom, input int width,
			input int margin, input int dense, input int life);
		drain();
		write_reg(CFG_TOP, top);
		write_reg(CFG_BOTTOM, bottom);
		write_reg(CFG_WIDTH, width);
		write_reg(CFG_MARGIN, margin);
		write_reg(CFG_DENSE, dense);
		write_reg(CFG_LIFE, life);
	endtask

	// one random item, biased towards a busy table with ids that repeat
	task automatic random_item(input int hmax);
		int sel, id, w, h, step, px, py, k;
		logic [2:0] op;
		sel = $urandom_range(0, 99);
		id = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 65535);
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
		h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, hmax);
		step = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
		px = $urandom_range(0, 4095);
		py = $urandom_range(0, 4095);
		if (sel < 50) op = OP_ADD;
		else if (sel < 62) op = OP_TICK;
		else if (sel < 84) op = OP_HIT;
		else if (sel < 94) op = OP_BLOCK;
		else if (sel < 97) op = OP_CLEAR;
		else op = 3'($urandom_range(5, 7));
		if (op == OP_HIT && bx_total > 0 && $urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, bx_total - 1);
			px = bx_left[k] + $urandom_range(0, bx_w[k]);
			py = bx_top[k] + $urandom_range(0, bx_h[k]);
		end
		send_item(op, pack_item(id, w, h, step, px, py));
	endtask

	task automatic test_directed();
		add_box(16'h0001, 100, 20);
		add_box(16'hFFFF, 4095, 4095);
		add_box(16'h0002, 0, 0);
		send_item(OP_HIT, pack_item(0, 0, 0, 0, 960, 1050));
		send_item(OP_HIT, pack_item(0, 0, 0, 0, 4095, 4095));
		send_item(OP_HIT, pack_item(0, 0, 0, 0, 0, 0));
		send_item(3'd5, pack_item(16'hFFFF, 4095, 4095, 16'hFFFF, 4095, 4095));
		send_item(3'd6, '1);
		send_item(3'd7, '0);
		send_item(OP_BLOCK, pack_item(16'hFFFF, 0, 0, 0, 0, 0));
		send_item(OP_TICK, pack_item(0, 0, 0, 4999, 0, 0));
		send_item(OP_TICK, pack_item(0, 0, 0, 1, 0, 0));
		add_box(3, 50, 10);
		send_item(OP_CLEAR, '0);
		add_box(4, 50, 10);
		send_item(OP_TICK, pack_item(0, 0, 0, 16'hFFFF, 0, 0));
	endtask

	// narrow surface with dense placement: overlaps into the largest gap
	task automatic test_dense();
		setup_surface(100, 300, 640, 10, 1, 65535);
		add_box(10, 50, 80);
		add_box(11, 50, 80);
		add_box(12, 50, 80);
		add_box(13, 50, 80);
		write_reg(CFG_DENSE, 0);
		add_box(14, 50, 80);
		write_reg(CFG_DENSE, 1);
		add_box(15, 700, 300);
		send_item(OP_CLEAR, '0);
		// no box held: placed at the bottom even though it is taller than the surface
		add_box(16, 10, 400);
		write_reg(8'd6, 16'hFFFF);
		write_reg(8'd255, 0);
	endtask

	task automatic test_random_phase(input int n, input int hmax);
		for (int j = 0; j < n; j++) random_item(hmax);
	endtask

	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		test_random_phase(20, 30);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b0;
		mismatches = 0; rx_hold = 0; rx_noidle = 0; tx_noidle = 0;
		shadow_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_dense();
		setup_surface(0, 4095, 4095, 0, 0, 65535);
		test_random_phase(200, 40);
		test_backpressure();
		setup_surface(4095, 0, 0, 255, 1, 1);
		test_random_phase(60, 20);
		setup_surface(0, 1080, 1920, 2, 0, 5000);
		rx_noidle = 1; tx_noidle = 1;
		test_random_phase(150, 60);
		rx_noidle = 0; tx_noidle = 0;
		setup_surface(200, 700, 1000, 8, 1, 800);
		test_random_phase(250, 80);
		setup_surface(0, 4095, 3000, 1, 0, 1);
		test_random_phase(60, 30);
		setup_surface(10, 3000, 2048, 255, 1, 20000);
		test_random_phase(200, 100);
		drain();

		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (rx_hold) m_tready <= 1'b0;
		else m_tready <= rx_noidle || ($urandom_range(0, 99) >= 35);
	end

	// handshakes are sampled at the falling edge, where all signals are settled
	always @(negedge clk) begin
		alloc_result_t want;
		alloc_result_t got;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) ||
					(m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.px     = m_tdata[14:2];
				got.py     = m_tdata[28:15];
				got.hit    = m_tdata[29];
				got.hid    = m_tdata[45:30];
				got.cnt    = m_tdata[51:46];
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
				end else begin
					want = pending_q.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d x=%0d y=%0d hit=%0d id=%0d n=%0d",
								want.status, $signed(want.px), $signed(want.py), want.hit,
								want.hid, want.cnt, " | got st=%0d x=%0d y=%0d hit=%0d id=%0d n=%0d",
								got.status, $signed(got.px), $signed(got.py), got.hit,
								got.hid, got.cnt);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
